// ===== rtl/bsph_pkg.sv =====
// ----------------------------------------------------------------------------
// bsph_pkg
// Types and constants shared by the bounding sphere block.
// ----------------------------------------------------------------------------
`default_nettype none

package bsph_pkg;

  localparam int unsigned DefMaxVerts = 64;

  localparam int unsigned CoordW = 24;             // Q12.12 coordinate
  localparam int unsigned DiffW  = CoordW + 1;     // coordinate minus center
  localparam int unsigned SqrW   = 2 * CoordW;     // |diff| < 2^24, square < 2^48
  localparam int unsigned SumW   = SqrW + 2;       // sum of three squares
  localparam int unsigned RootSteps = SumW / 2;    // one result bit per step
  localparam int unsigned StepW  = $clog2(RootSteps);
  localparam int unsigned NumAxes = 3;

  typedef struct packed {
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
    logic                     last_vertex;
  } vert_t;

  typedef struct packed {
    logic signed [CoordW-1:0] center_x;
    logic signed [CoordW-1:0] center_y;
    logic signed [CoordW-1:0] center_z;
    logic        [CoordW-1:0] radius;
    logic                     overflow;
  } sphere_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CENTER,
    ST_PASS,
    ST_ROOT
  } state_e;

endpackage

`default_nettype wire

// ===== rtl/point_set_bounding_sphere.sv =====
// ----------------------------------------------------------------------------
// point_set_bounding_sphere
// Bounding sphere of a vertex set: center at the box midpoint, radius the
// floor square root of the largest squared distance to a stored vertex.
// ----------------------------------------------------------------------------
// Non-last vertex: busy stays low; a vertex can be taken every cycle while idle.
// Last vertex: the result strobe follows the center state, a radius pass of
//   n memory reads (n = stored vertices) through the read, difference, square
//   and sum registers, the drain, then the bit-serial square root. busy is high
//   throughout; the result is shown for one cycle and cannot be stalled.
// Reset clears control state and the set; the vertex memory holds no reset.
`default_nettype none

module point_set_bounding_sphere #(
  parameter int unsigned MAX_VERTS = bsph_pkg::DefMaxVerts
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output      logic            busy,
  input  wire bsph_pkg::vert_t vert_i,
  output      logic            result_valid_o,
  output bsph_pkg::sphere_t    result_o
);

  localparam int unsigned CoordW = bsph_pkg::CoordW;
  localparam int unsigned DiffW  = bsph_pkg::DiffW;
  localparam int unsigned SqrW   = bsph_pkg::SqrW;
  localparam int unsigned SumW   = bsph_pkg::SumW;
  localparam int unsigned NumAxes = bsph_pkg::NumAxes;
  localparam int unsigned StepW  = bsph_pkg::StepW;
  localparam int unsigned CntW   = $clog2(MAX_VERTS + 1);
  localparam int unsigned AddrW  = (MAX_VERTS > 1) ? $clog2(MAX_VERTS) : 1;
  localparam int unsigned WordW  = NumAxes * CoordW;

  bsph_pkg::state_e state_q, state_d;

  logic [CntW-1:0]  count_q;
  logic             ovf_q;
  logic [CntW-1:0]  rd_idx_q;
  logic             v1_q, v2_q, v3_q, v4_q;
  logic [StepW-1:0] step_q;

  logic signed [CoordW-1:0] lo_q  [NumAxes];
  logic signed [CoordW-1:0] hi_q  [NumAxes];
  logic signed [CoordW-1:0] ctr_q [NumAxes];
  logic signed [DiffW-1:0]  diff_q[NumAxes];
  logic        [SqrW-1:0]   sq_q  [NumAxes];
  logic        [SumW-1:0]   sum_q;
  logic        [SumW-1:0]   best_q;
  logic        [SumW-1:0]   rem_q;
  logic        [SumW-1:0]   root_q;
  logic        [SumW-1:0]   bit_q;

  logic signed [CoordW-1:0] pos   [NumAxes];
  logic signed [CoordW-1:0] rd_co [NumAxes];
  logic signed [2*DiffW-1:0] prod [NumAxes];
  logic signed [CoordW:0]    box_sum [NumAxes];

  logic [WordW-1:0] mem [MAX_VERTS];
  logic [WordW-1:0] rd_q;

  logic accept, first, has_room, issue, pipe_busy, root_last;
  logic [SumW:0]   trial;
  logic            take;
  logic [SumW-1:0] sum_d;
  logic [SumW-1:0] root_d;

  assign busy     = (state_q != bsph_pkg::ST_IDLE);
  assign accept   = start & ~busy;
  assign first    = (count_q == '0) & ~ovf_q;
  assign has_room = (count_q < CntW'(MAX_VERTS));
  assign issue    = (state_q == bsph_pkg::ST_PASS) & (rd_idx_q < count_q);
  assign pipe_busy = v1_q | v2_q | v3_q | v4_q;
  assign root_last = (step_q == StepW'(bsph_pkg::RootSteps - 1));

  assign pos[0] = vert_i.pos_x;
  assign pos[1] = vert_i.pos_y;
  assign pos[2] = vert_i.pos_z;

  // memory word packs x in the top lane
  always_comb begin
    for (int a = 0; a < NumAxes; a++) begin
      rd_co[a]   = rd_q[(NumAxes-1-a)*CoordW +: CoordW];
      prod[a]    = diff_q[a] * diff_q[a];
      box_sum[a] = {lo_q[a][CoordW-1], lo_q[a]} + {hi_q[a][CoordW-1], hi_q[a]};
    end
    sum_d  = SumW'(sq_q[0]) + SumW'(sq_q[1]) + SumW'(sq_q[2]);
    trial  = {1'b0, root_q} + {1'b0, bit_q};
    take   = ({1'b0, rem_q} >= trial);
    root_d = take ? ((root_q >> 1) + bit_q) : (root_q >> 1);
  end

  // ---------------------------------------------------------------------------
  // Next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bsph_pkg::ST_IDLE: begin
        if (accept && vert_i.last_vertex) state_d = bsph_pkg::ST_CENTER;
      end
      bsph_pkg::ST_CENTER: begin
        state_d = bsph_pkg::ST_PASS;
      end
      bsph_pkg::ST_PASS: begin
        if (!issue && !pipe_busy) state_d = bsph_pkg::ST_ROOT;
      end
      bsph_pkg::ST_ROOT: begin
        if (root_last) state_d = bsph_pkg::ST_IDLE;
      end
      default: state_d = bsph_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= bsph_pkg::ST_IDLE;
      count_q        <= '0;
      ovf_q          <= 1'b0;
      rd_idx_q       <= '0;
      v1_q           <= 1'b0;
      v2_q           <= 1'b0;
      v3_q           <= 1'b0;
      v4_q           <= 1'b0;
      step_q         <= '0;
      result_valid_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      v1_q           <= issue;
      v2_q           <= v1_q;
      v3_q           <= v2_q;
      v4_q           <= v3_q;
      result_valid_o <= 1'b0;
      if (accept) begin
        if (has_room) count_q <= count_q + CntW'(1);
        else          ovf_q   <= 1'b1;
      end
      if (state_q == bsph_pkg::ST_CENTER) rd_idx_q <= '0;
      else if (issue)                     rd_idx_q <= rd_idx_q + CntW'(1);
      if (state_q == bsph_pkg::ST_PASS) step_q <= '0;
      else if (state_q == bsph_pkg::ST_ROOT) step_q <= step_q + StepW'(1);
      if (state_q == bsph_pkg::ST_ROOT && root_last) begin
        result_valid_o <= 1'b1;
        count_q        <= '0;
        ovf_q          <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Vertex memory, one write and one registered read port
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (accept && has_room) begin
      mem[count_q[AddrW-1:0]] <= {vert_i.pos_x, vert_i.pos_y, vert_i.pos_z};
    end
    rd_q <= mem[rd_idx_q[AddrW-1:0]];
  end

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    for (int a = 0; a < NumAxes; a++) begin
      if (accept) begin
        if (first || pos[a] < lo_q[a]) lo_q[a] <= pos[a];
        if (first || pos[a] > hi_q[a]) hi_q[a] <= pos[a];
      end
      // floor midpoint: arithmetic shift of the 25-bit sum
      if (state_q == bsph_pkg::ST_CENTER) ctr_q[a] <= box_sum[a][CoordW:1];
      diff_q[a] <= {rd_co[a][CoordW-1], rd_co[a]} - {ctr_q[a][CoordW-1], ctr_q[a]};
      sq_q[a]   <= prod[a][SqrW-1:0];
    end
    sum_q <= sum_d;

    if (state_q == bsph_pkg::ST_CENTER)    best_q <= '0;
    else if (v4_q && sum_q > best_q)       best_q <= sum_q;

    // restoring square root, one result bit per cycle
    if (state_q == bsph_pkg::ST_PASS) begin
      rem_q  <= best_q;
      root_q <= '0;
      bit_q  <= SumW'(1) << (SumW - 2);
    end else if (state_q == bsph_pkg::ST_ROOT) begin
      if (take) begin
        rem_q  <= rem_q - trial[SumW-1:0];
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
      if (root_last) begin
        result_o.center_x <= ctr_q[0];
        result_o.center_y <= ctr_q[1];
        result_o.center_z <= ctr_q[2];
        result_o.radius   <= root_d[CoordW-1:0];
        result_o.overflow <= ovf_q;
      end
    end
  end

endmodule

`default_nettype wire
